/* rtl/core/subtitle_tag_stripper_macros.svh */
// Assertion macros for the subtitle tag stripper.
`ifndef SUBTITLE_TAG_STRIPPER_MACROS_SVH
`define SUBTITLE_TAG_STRIPPER_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define STS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sts_pkg.sv */
// Shared constants and types for the subtitle tag stripper.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int unsigned TAG_DEPTH_DEF = 63;
  localparam logic [15:0] MAX_LEN_RST = 16'd511;

  localparam logic OP_TEXT = 1'b0;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_UPPER_N = 8'h4E;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;

  typedef struct packed {
    logic [7:0] ch_res;
    logic       has_char;
    logic       last;
    logic       overflow;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/sts_tag_mem.sv */
// Tag store: single-port-write, registered-read memory of raw tag bytes.
`timescale 1ns / 1ps
`default_nettype none

module sts_tag_mem #(
  parameter int unsigned Depth = sts_pkg::TAG_DEPTH_DEF,
  parameter int unsigned Aw    = $clog2(sts_pkg::TAG_DEPTH_DEF)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/sts_out_buf.sv */
// Output register between the stripper core and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module sts_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sts_pkg::res_t res_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sts_pkg::res_t      res_o
);

  logic          valid_q, valid_d;
  sts_pkg::res_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/core/subtitle_tag_stripper.sv */
// Subtitle tag stripper: removes brace override tags from streamed subtitle text.
//
// Text bytes arrive with op 0, the end of a string with op 1. A text byte
// that releases a held backslash ahead of itself yields two results, the
// second sent from the EMIT2 state; each result goes through a single output
// register, so a stalled output holds the input. The end item of a string
// left inside an open tag replays the stored tag bytes, each read from the
// tag store memory in the RD state and sent in the WR state. max_len may be
// written whenever no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "subtitle_tag_stripper_macros.svh"

module subtitle_tag_stripper #(
  parameter int unsigned TAG_DEPTH = sts_pkg::TAG_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  ch_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [7:0]  ch_res_o,
  output logic             has_char_o,
  output logic             last_o,
  output logic             overflow_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_max_len_i
);

  localparam int unsigned AW = $clog2(TAG_DEPTH);
  localparam int unsigned CW = $clog2(TAG_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT2,
    ST_RD,
    ST_WR
  } state_e;

  state_e        state_q, state_d;
  logic          inside_q, inside_d;
  logic          draw_q, draw_d;
  logic          pdig_q, pdig_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] tcnt_q, tcnt_d;
  logic          tovf_q, tovf_d;
  logic [15:0]   ocnt_q, ocnt_d;
  logic [15:0]   max_len_q;
  logic [7:0]    hold_q, hold_d;
  logic [CW-1:0] idx_q, idx_d;

  logic          obuf_ready;
  logic          in_acc;
  logic          push;
  sts_pkg::res_t res;
  sts_pkg::res_t res_out;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [7:0]    rdata;

  assign in_stall_o  = !((state_q == ST_IDLE) && obuf_ready);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic       done;
    logic       want_a;
    logic       want_b;
    logic [7:0] a_ch;
    logic       is_digit;
    logic       rlast;

    done     = 1'b0;
    want_a   = 1'b0;
    want_b   = 1'b0;
    a_ch     = sts_pkg::CH_BSLASH;
    is_digit = (ch_i >= sts_pkg::CH_0) && (ch_i <= sts_pkg::CH_9);
    rlast    = 1'b0;

    state_d  = state_q;
    inside_d = inside_q;
    draw_d   = draw_q;
    pdig_d   = pdig_q;
    pend_d   = pend_q;
    tcnt_d   = tcnt_q;
    tovf_d   = tovf_q;
    ocnt_d   = ocnt_q;
    hold_d   = hold_q;
    idx_d    = idx_q;
    push     = 1'b0;
    res      = '0;
    we       = 1'b0;
    waddr    = tcnt_q[AW-1:0];
    wdata    = ch_i;
    re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == sts_pkg::OP_TEXT) begin
            if (inside_q) begin
              if (tcnt_q < CW'(TAG_DEPTH)) begin
                we     = 1'b1;
                tcnt_d = tcnt_q + 1'b1;
              end else begin
                tovf_d = 1'b1;
              end
              if (pend_q) begin
                pend_d = 1'b0;
                if (ch_i == sts_pkg::CH_P) begin
                  draw_d = 1'b0;
                  pdig_d = 1'b1;
                  done   = 1'b1;
                end
              end
              if (!done && pdig_q) begin
                if (is_digit) begin
                  if (ch_i != sts_pkg::CH_0) begin
                    draw_d = 1'b1;
                  end
                  done = 1'b1;
                end else begin
                  pdig_d = 1'b0;
                end
              end
              if (!done) begin
                if (ch_i == sts_pkg::CH_RBRACE) begin
                  inside_d = 1'b0;
                  tcnt_d   = '0;
                  tovf_d   = 1'b0;
                end else if (ch_i == sts_pkg::CH_BSLASH) begin
                  pend_d = 1'b1;
                end
              end
            end else begin
              if (pend_q) begin
                pend_d = 1'b0;
                if ((ch_i == sts_pkg::CH_UPPER_N) || (ch_i == sts_pkg::CH_LOWER_N)) begin
                  a_ch   = sts_pkg::CH_NL;
                  want_a = 1'b1;
                  done   = 1'b1;
                end else if (ch_i == sts_pkg::CH_H) begin
                  a_ch   = sts_pkg::CH_SP;
                  want_a = 1'b1;
                  done   = 1'b1;
                end else if (!draw_q) begin
                  want_a = 1'b1;
                end
              end
              if (!done) begin
                if (ch_i == sts_pkg::CH_BSLASH) begin
                  pend_d = 1'b1;
                end else if (ch_i == sts_pkg::CH_LBRACE) begin
                  inside_d = 1'b1;
                  tovf_d   = 1'b0;
                  tcnt_d   = CW'(1);
                  we       = 1'b1;
                  waddr    = '0;
                end else if (!draw_q) begin
                  want_b = 1'b1;
                end
              end
              if ((want_a || want_b) && (ocnt_q < max_len_q)) begin
                push         = 1'b1;
                res.ch_res   = want_a ? a_ch : ch_i;
                res.has_char = 1'b1;
                ocnt_d       = ocnt_q + 16'd1;
              end
              if (want_a && want_b) begin
                hold_d  = ch_i;
                state_d = ST_EMIT2;
              end
            end
          end else begin
            if (inside_q && (tcnt_q != '0) && (ocnt_q < max_len_q)) begin
              idx_d   = '0;
              state_d = ST_RD;
            end else begin
              push         = 1'b1;
              res.last     = 1'b1;
              res.overflow = inside_q && tovf_q;
              if (!inside_q && pend_q && !draw_q && (ocnt_q < max_len_q)) begin
                res.ch_res   = sts_pkg::CH_BSLASH;
                res.has_char = 1'b1;
              end
              inside_d = 1'b0;
              draw_d   = 1'b0;
              pdig_d   = 1'b0;
              pend_d   = 1'b0;
              tcnt_d   = '0;
              tovf_d   = 1'b0;
              ocnt_d   = '0;
            end
          end
        end
      end
      ST_EMIT2: begin
        if (obuf_ready) begin
          if (ocnt_q < max_len_q) begin
            push         = 1'b1;
            res.ch_res   = hold_q;
            res.has_char = 1'b1;
            ocnt_d       = ocnt_q + 16'd1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        re      = 1'b1;
        state_d = ST_WR;
      end
      ST_WR: begin
        if (obuf_ready) begin
          rlast        = (CW'(idx_q + 1'b1) == tcnt_q) || ((ocnt_q + 16'd1) == max_len_q);
          push         = 1'b1;
          res.ch_res   = rdata;
          res.has_char = 1'b1;
          res.last     = rlast;
          res.overflow = tovf_q;
          ocnt_d       = ocnt_q + 16'd1;
          if (rlast) begin
            inside_d = 1'b0;
            draw_d   = 1'b0;
            pdig_d   = 1'b0;
            pend_d   = 1'b0;
            tcnt_d   = '0;
            tovf_d   = 1'b0;
            ocnt_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      inside_q  <= 1'b0;
      draw_q    <= 1'b0;
      pdig_q    <= 1'b0;
      pend_q    <= 1'b0;
      tcnt_q    <= '0;
      tovf_q    <= 1'b0;
      ocnt_q    <= '0;
      max_len_q <= sts_pkg::MAX_LEN_RST;
      idx_q     <= '0;
    end else begin
      state_q  <= state_d;
      inside_q <= inside_d;
      draw_q   <= draw_d;
      pdig_q   <= pdig_d;
      pend_q   <= pend_d;
      tcnt_q   <= tcnt_d;
      tovf_q   <= tovf_d;
      ocnt_q   <= ocnt_d;
      idx_q    <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_len_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  sts_tag_mem #(
    .Depth (TAG_DEPTH),
    .Aw    (AW)
  ) u_tag_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  sts_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .ready_o     (obuf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign ch_res_o   = res_out.ch_res;
  assign has_char_o = res_out.has_char;
  assign last_o     = res_out.last;
  assign overflow_o = res_out.overflow;

  `STS_ASSERT_IMP(a_push_room, push, obuf_ready, "item pushed into a full output register")
  `STS_ASSERT_ALWAYS(a_tcnt_range, tcnt_q <= CW'(TAG_DEPTH), "tag count beyond tag store")
  `STS_ASSERT_IMP(a_replay_in_tag, (state_q == ST_RD) || (state_q == ST_WR), inside_q, "replay outside a tag")
  `STS_ASSERT_NXT(a_last_idle, push && res.last, state_q == ST_IDLE, "final item did not return to idle")

endmodule

`default_nettype wire
